### rtl/c2dv_pkg.sv
package c2dv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 5;
    localparam int RESULT_W = 36;
    localparam int POS_W    = 5;

    localparam logic KIND_COEF  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } c2dv_pos_t;

endpackage

### rtl/conv2d_valid_flipped_kernel_unit.sv
// Streaming valid 2D convolution of one image channel with a square
// KERNEL_SIZE x KERNEL_SIZE kernel. A request with kind 0 loads the coefficient
// at coef_index (row*K+col; indexes beyond K*K-1 are dropped); a request with
// kind 1 is the next pixel of a row-major IMAGE_WIDTH x IMAGE_HEIGHT frame.
// Every pixel that completes a window produces one result
// sum of in[R+m][C+n] * coef[K-1-m][K-1-n], wrapped to 36 bits, with its output
// row and column and a last flag on the final result of the frame. Coefficient
// loads take effect for every pixel that follows them. The block accepts one
// request per clock unless m_ready stalls the pipeline; a result passes through
// input register, K*K parallel multipliers, row sums, final sum. The previous
// K-1 rows live in a line memory of IMAGE_WIDTH words of K-1 pixels, read at
// accept and written back as the pixel leaves the input register; the window
// and kernel are flops.
// Each pipeline stage holds its request independently, so input keeps flowing
// while a result waits on m_ready until the stages fill.
module conv2d_valid_flipped_kernel_unit #(
    parameter int IMAGE_WIDTH  = 32,
    parameter int IMAGE_HEIGHT = 32,
    parameter int KERNEL_SIZE  = 5,
    parameter int DATA_WIDTH   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic [c2dv_pkg::IDX_W-1:0]           s_coef_index,
    input  logic signed [c2dv_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [c2dv_pkg::RESULT_W-1:0] m_result,
    output logic [c2dv_pkg::POS_W-1:0]           m_out_row,
    output logic [c2dv_pkg::POS_W-1:0]           m_out_col,
    output logic                                 m_last
);
    import c2dv_pkg::*;

    localparam int K     = KERNEL_SIZE;
    localparam int KK    = K * K;
    localparam int DW    = DATA_WIDTH;
    localparam int LANES = (K > 1) ? K - 1 : 1;
    localparam int COLW  = $clog2(IMAGE_WIDTH);
    localparam int ROWW  = $clog2(IMAGE_HEIGHT);

    typedef logic [DW-1:0] pix_t;
    typedef logic [RESULT_W-1:0] acc_t;

    logic rdy1, rdy2, rdy3, rdy4;
    logic accept, fire1, pix_fire, full;
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;

    logic             kind1_reg;
    logic [IDX_W-1:0] idx1_reg;
    pix_t             pix1_reg;
    logic [COLW-1:0]  col1_reg;
    logic [COLW-1:0]  acol_reg, acol_next;
    logic [ROWW-1:0]  row_reg, row_next;
    logic [31:0]      pix_ext;
    logic [31:0]      r_off, c_off;

    pix_t [LANES-1:0] line_mem [IMAGE_WIDTH];
    pix_t [LANES-1:0] rd_reg;
    pix_t [LANES-1:0] wr_word;
    pix_t [K-1:0]     col_vec;

    pix_t win_reg  [K][K];
    pix_t win_next [K][K];
    pix_t kern_reg [KK];

    acc_t prod_next [K][K];
    acc_t prod_reg  [K][K];
    acc_t rsum_next [K];
    acc_t rsum_reg  [K];
    acc_t total_next;
    acc_t result_reg;

    c2dv_pos_t pos_next, pos2_reg, pos3_reg, pos4_reg;

    // stage handshake
    assign rdy4     = !m_valid_reg || m_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_ready  = rdy1;
    assign accept   = s_valid && rdy1;
    assign fire1    = v1_reg && rdy2;
    assign pix_fire = fire1 && (kind1_reg == KIND_PIXEL);

    // wider data widths take the sample zero-extended
    assign pix_ext = {16'b0, s_sample};

    always_comb begin
        acol_next = acol_reg;
        if (accept && s_kind == KIND_PIXEL) begin
            if (acol_reg == COLW'(IMAGE_WIDTH - 1)) begin
                acol_next = '0;
            end else begin
                acol_next = acol_reg + 1'b1;
            end
        end
    end

    always_comb begin
        row_next = row_reg;
        if (pix_fire && col1_reg == COLW'(IMAGE_WIDTH - 1)) begin
            if (row_reg == ROWW'(IMAGE_HEIGHT - 1)) begin
                row_next = '0;
            end else begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    // column of the window: K-1 buffered rows plus the new pixel
    always_comb begin
        int m, n, src;
        for (m = 0; m < K; m++) begin
            if (m == K - 1) begin
                col_vec[m] = pix1_reg;
            end else begin
                col_vec[m] = rd_reg[m];
            end
        end
        for (m = 0; m < LANES; m++) begin
            src = (m + 1 < K) ? m + 1 : K - 1;
            wr_word[m] = col_vec[src];
        end
        for (m = 0; m < K; m++) begin
            for (n = 0; n < K; n++) begin
                if (n == K - 1) begin
                    win_next[m][n] = col_vec[m];
                end else begin
                    win_next[m][n] = win_reg[m][n + 1];
                end
            end
        end
    end

    always_comb begin
        int m, n;
        logic [63:0] p;
        p = '0;
        for (m = 0; m < K; m++) begin
            for (n = 0; n < K; n++) begin
                p = 64'($signed(win_next[m][n]) *
                        $signed(kern_reg[(K - 1 - m) * K + (K - 1 - n)]));
                prod_next[m][n] = p[RESULT_W-1:0];
            end
        end
    end

    always_comb begin
        int m, n;
        for (m = 0; m < K; m++) begin
            rsum_next[m] = '0;
            for (n = 0; n < K; n++) begin
                rsum_next[m] = rsum_next[m] + prod_reg[m][n];
            end
        end
        total_next = '0;
        for (m = 0; m < K; m++) begin
            total_next = total_next + rsum_reg[m];
        end
    end

    assign full  = (row_reg >= ROWW'(K - 1)) && (col1_reg >= COLW'(K - 1));
    assign r_off = 32'(row_reg) - 32'(K - 1);
    assign c_off = 32'(col1_reg) - 32'(K - 1);

    always_comb begin
        pos_next.row  = r_off[POS_W-1:0];
        pos_next.col  = c_off[POS_W-1:0];
        pos_next.last = (row_reg == ROWW'(IMAGE_HEIGHT - 1)) &&
                        (col1_reg == COLW'(IMAGE_WIDTH - 1));
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            acol_reg    <= '0;
            row_reg     <= '0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= pix_fire && full;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                m_valid_reg <= v3_reg;
            end
            acol_reg <= acol_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KK; i++) begin
                kern_reg[i] <= '0;
            end
        end else if (fire1 && kind1_reg == KIND_COEF) begin
            for (int i = 0; i < KK; i++) begin
                if (32'(idx1_reg) == i) begin
                    kern_reg[i] <= pix1_reg;
                end
            end
        end
    end

    // line memory: read at accept, write back when the pixel moves on
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= line_mem[acol_reg];
        end
        if (pix_fire) begin
            line_mem[col1_reg] <= wr_word;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind1_reg <= s_kind;
            idx1_reg  <= s_coef_index;
            pix1_reg  <= pix_ext[DW-1:0];
            col1_reg  <= acol_reg;
        end
        if (pix_fire) begin
            win_reg <= win_next;
        end
        if (rdy2) begin
            prod_reg <= prod_next;
            pos2_reg <= pos_next;
        end
        if (rdy3) begin
            rsum_reg <= rsum_next;
            pos3_reg <= pos2_reg;
        end
        if (rdy4) begin
            result_reg <= total_next;
            pos4_reg   <= pos3_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_result  = signed'(result_reg);
    assign m_out_row = pos4_reg.row;
    assign m_out_col = pos4_reg.col;
    assign m_last    = pos4_reg.last;

endmodule

### verif/tb_conv2d_valid_flipped_kernel_unit.sv
module tb_conv2d_valid_flipped_kernel_unit;
    import c2dv_pkg::*;

    localparam int IMG_W = 32;
    localparam int IMG_H = 32;
    localparam int KSZ   = 5;
    localparam int NCOEF = KSZ * KSZ;
    localparam int LIMIT = 100000;

    typedef struct {
        bit                         pause;
        logic                       kind;
        logic [IDX_W-1:0]           idx;
        logic signed [SAMPLE_W-1:0] sample;
    } conv_req_t;

    typedef struct {
        logic signed [RESULT_W-1:0] sum;
        logic [POS_W-1:0]           row;
        logic [POS_W-1:0]           col;
        logic                       last;
    } conv_res_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_kind = KIND_COEF;
    logic [IDX_W-1:0]           s_coef_index = '0;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [RESULT_W-1:0] m_result;
    logic [POS_W-1:0]           m_out_row;
    logic [POS_W-1:0]           m_out_col;
    logic                       m_last;

    conv_req_t req_queue[$];
    conv_res_t exp_results[$];

    // predictor state
    logic signed [SAMPLE_W-1:0] coef_mem [NCOEF];
    logic signed [SAMPLE_W-1:0] row_mem [KSZ][IMG_W];
    int pix_r = 0;
    int pix_c = 0;

    int gen_items = 0;
    int gen_pix   = 0;
    int sent_cnt  = 0;
    int got_cnt   = 0;
    int frame_cnt = 0;
    int err_cnt   = 0;
    int cyc       = 0;
    int hold_cnt  = 0;
    bit hold_done = 1'b0;

    conv2d_valid_flipped_kernel_unit #(
        .IMAGE_WIDTH (IMG_W),
        .IMAGE_HEIGHT(IMG_H),
        .KERNEL_SIZE (KSZ),
        .DATA_WIDTH  (SAMPLE_W)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_coef_index(s_coef_index),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_last      (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic conv_predict(input conv_req_t rq);
        int br;
        int bc;
        longint acc;
        conv_res_t res;
        if (rq.kind == KIND_COEF) begin
            if (rq.idx < NCOEF) coef_mem[rq.idx] = rq.sample;
            return;
        end
        row_mem[pix_r % KSZ][pix_c] = rq.sample;
        if (pix_r >= KSZ - 1 && pix_c >= KSZ - 1) begin
            br = pix_r - (KSZ - 1);
            bc = pix_c - (KSZ - 1);
            acc = 0;
            for (int m = 0; m < KSZ; m++) begin
                for (int n = 0; n < KSZ; n++) begin
                    acc += longint'(row_mem[(br + m) % KSZ][bc + n])
                         * longint'(coef_mem[(KSZ - 1 - m) * KSZ + (KSZ - 1 - n)]);
                end
            end
            res.sum  = acc[RESULT_W-1:0];
            res.row  = br[POS_W-1:0];
            res.col  = bc[POS_W-1:0];
            res.last = (pix_r == IMG_H - 1 && pix_c == IMG_W - 1);
            exp_results.push_back(res);
        end
        if (pix_c + 1 >= IMG_W) begin
            pix_c = 0;
            pix_r = (pix_r + 1 >= IMG_H) ? 0 : pix_r + 1;
        end else begin
            pix_c++;
        end
    endtask

    task automatic push_item(input logic kind, input int idx, input int val);
        conv_req_t rq;
        rq.pause  = 1'b0;
        rq.kind   = kind;
        rq.idx    = idx[IDX_W-1:0];
        rq.sample = val[SAMPLE_W-1:0];
        req_queue.push_back(rq);
        gen_items++;
        if (kind == KIND_PIXEL) gen_pix++;
    endtask

    task automatic push_pause();
        conv_req_t rq;
        rq = '{pause: 1'b1, kind: KIND_COEF, idx: '0, sample: '0};
        req_queue.push_back(rq);
    endtask

    function automatic int pick_sample(input int mode);
        int v;
        case (mode)
            0: v = $urandom_range(65535);
            1: begin
                case ($urandom_range(3))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom_range(8)) - 4;
        endcase
        return v;
    endfunction

    // driver
    always @(posedge aclk) begin
        conv_req_t rq;
        bit busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                rq.pause  = 1'b0;
                rq.kind   = s_kind;
                rq.idx    = s_coef_index;
                rq.sample = s_sample;
                conv_predict(rq);
                sent_cnt++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (req_queue.size() > 0 && req_queue[0].pause && exp_results.size() == 0)
                    void'(req_queue.pop_front());
                if (req_queue.size() > 0 && !req_queue[0].pause &&
                    !((sent_cnt < 400 || sent_cnt >= 600) && $urandom_range(99) < 25)) begin
                    rq = req_queue.pop_front();
                    s_kind       <= rq.kind;
                    s_coef_index <= rq.idx;
                    s_sample     <= rq.sample;
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        conv_res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_cnt++;
                if (m_last) frame_cnt++;
                if (exp_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result: sum=%0d row=%0d col=%0d last=%0b",
                                 m_result, m_out_row, m_out_col, m_last);
                end else begin
                    want = exp_results.pop_front();
                    if (m_result !== want.sum || m_out_row !== want.row ||
                        m_out_col !== want.col || m_last !== want.last) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("mismatch at result %0d: expected sum=%0d row=%0d col=%0d last=%0b",
                                     got_cnt, want.sum, want.row, want.col, want.last);
                            $display("    got sum=%0d row=%0d col=%0d last=%0b",
                                     m_result, m_out_row, m_out_col, m_last);
                        end
                    end
                end
            end
            m_ready <= (hold_cnt == 0) &&
                       !((got_cnt < 250 || got_cnt >= 450) && $urandom_range(99) < 25);
        end
    end

    // long receiver hold-off to back up the pipeline
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && got_cnt >= 500) begin
            hold_cnt  <= 200;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("conv2d_valid_flipped_kernel_unit test failed");
            $finish;
        end
    end

    initial begin
        int mode;
        int seg_len;
        int runval;
        foreach (coef_mem[i]) coef_mem[i] = '0;
        foreach (row_mem[i, j]) row_mem[i][j] = '0;

        // directed: coefficient extremes, dropped indexes, pixel extremes
        push_item(KIND_COEF, 0, 32767);
        push_item(KIND_COEF, NCOEF - 1, -32768);
        push_item(KIND_COEF, 12, -1);
        push_item(KIND_COEF, 6, 1);
        push_item(KIND_COEF, NCOEF, 16'h5a5a);
        push_item(KIND_COEF, 31, -32768);
        push_item(KIND_COEF, 16, 16'h7fff);
        push_item(KIND_PIXEL, 0, 32767);
        push_item(KIND_PIXEL, 0, -32768);
        push_item(KIND_PIXEL, 0, 0);
        push_item(KIND_PIXEL, 0, -1);
        push_item(KIND_PIXEL, 0, 1);
        push_item(KIND_PIXEL, 0, 16'h5555);
        push_item(KIND_PIXEL, 0, 16'haaaa);
        push_item(KIND_COEF, 24, 0);
        push_item(KIND_COEF, 0, 3);
        push_pause();

        // enough pixels to close one full frame
        for (int seg = 0; gen_pix < 1030; seg++) begin
            mode = (seg == 2 || seg == 5) ? 3 : $urandom_range(2);
            seg_len = (mode == 3) ? 160 : 50;
            if (seg == 3) push_pause();
            // extreme-value segment: full kernel of -32768, constant pixels
            if (mode == 3) begin
                for (int i = 0; i < NCOEF; i++) push_item(KIND_COEF, i, -32768);
                runval = (seg == 2) ? -32768 : 32767;
            end
            repeat (seg_len) begin
                if ($urandom_range(99) < 6) begin
                    push_item(KIND_COEF,
                              ($urandom_range(7) == 0) ? $urandom_range(31, NCOEF)
                                                       : $urandom_range(NCOEF - 1),
                              (mode == 3) ? -32768 : pick_sample(mode));
                end else begin
                    push_item(KIND_PIXEL, $urandom_range(31),
                              (mode == 3) ? runval : pick_sample(mode));
                end
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_queue.size() != 0 || s_valid) @(posedge aclk);
        while (exp_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d requests sent (%0d pixels), %0d results checked, %0d frames ended",
                 sent_cnt, gen_pix, got_cnt, frame_cnt);
        $display("%0d mismatches, %0d results outstanding", err_cnt, exp_results.size());
        if (err_cnt == 0 && exp_results.size() == 0) begin
            $display("conv2d_valid_flipped_kernel_unit test passed");
        end else begin
            $display("conv2d_valid_flipped_kernel_unit test failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/c2dv_pkg.sv
rtl/conv2d_valid_flipped_kernel_unit.sv
verif/tb_conv2d_valid_flipped_kernel_unit.sv
